// ===== rtl/core/pfrs_pkg.sv =====
// Package for the PUCCH format and resource selection block.
// Holds the request, result and configuration types and the format and register codes.
// Depends on nothing; every other file of the block uses it.
package pfrs_pkg;

	localparam int CQI_BITS   = 20;
	localparam int RES_IDX_W  = 11;
	localparam int CFG_DATA_W = 44;
	localparam int CFG_IDX_W  = 3;

	localparam logic [2:0] FMT_1  = 3'd0;
	localparam logic [2:0] FMT_1A = 3'd1;
	localparam logic [2:0] FMT_1B = 3'd2;
	localparam logic [2:0] FMT_2  = 3'd3;
	localparam logic [2:0] FMT_2A = 3'd4;
	localparam logic [2:0] FMT_2B = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_SR_RESOURCE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPS_ENABLE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPS_TABLE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TPC_FIELD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CCE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_OFFSET    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CQI_RESOURCE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENDED_CP   = 3'd7;

	typedef struct packed {
		logic [1:0]          ack_len;
		logic                ack_first;
		logic                ack_second;
		logic                sched_request;
		logic                chan_select;
		logic [4:0]          cqi_len;
		logic [CQI_BITS-1:0] cqi_bits;
	} req_t;

	typedef struct packed {
		logic                status;
		logic [2:0]          format_code;
		logic [11:0]         resource_index;
		logic [CQI_BITS-1:0] payload_bits;
		logic [1:0]          dmrs_bits;
	} res_t;

	typedef struct packed {
		logic [RES_IDX_W-1:0]        sr_resource;
		logic                        sps_enable;
		logic [3:0][RES_IDX_W-1:0]   sps_table;
		logic [1:0]                  tpc_field;
		logic [6:0]                  first_cce;
		logic [RES_IDX_W-1:0]        ack_offset;
		logic [RES_IDX_W-1:0]        cqi_resource;
		logic                        extended_cp;
	} cfg_t;

endpackage

// ===== rtl/core/pfrs_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on pfrs_pkg for the word types.
interface pfrs_req_if;
	logic           valid;
	logic           ready;
	pfrs_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pfrs_res_if;
	logic           valid;
	logic           ready;
	pfrs_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/pucch_format_and_resource_select.sv =====
// The block takes one uplink control request word per cycle unless a waiting result holds
// it off, and returns one result word per request. The request is registered, the format
// chain and resource pick run between that register and the result register, and the result
// register lets a new request in while a finished result still waits to be taken.
// The user must write configuration registers via cfg_we, cfg_index, cfg_data only while idle; not enforced.
// Top level; depends on pfrs_pkg, pfrs_if, pfrs_cfg_regs and pfrs_select.
module pucch_format_and_resource_select (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pfrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfrs_pkg::CFG_DATA_W-1:0] cfg_data,
	pfrs_req_if.sink                        req,
	pfrs_res_if.source                      rsp
);

	pfrs_pkg::cfg_t cfg;
	pfrs_pkg::req_t req_s1;
	pfrs_pkg::res_t sel;
	pfrs_pkg::res_t res_s2;
	logic           v_s1;
	logic           v_s2;
	logic           adv;

	pfrs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfrs_select u_select (
		.req (req_s1),
		.cfg (cfg),
		.res (sel)
	);

	assign adv       = ~v_s2 | rsp.ready;
	assign req.ready = ~v_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (adv && v_s1) begin
			res_s2 <= sel;
		end
	end

	assign rsp.valid = v_s2;
	assign rsp.data  = res_s2;

	// An error word carries nothing but its status bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status) |-> (rsp.data.format_code == 3'd0 &&
		rsp.data.resource_index == 12'd0 && rsp.data.payload_bits == '0 &&
		rsp.data.dmrs_bits == 2'd0))
	else $error("error word with non-zero fields");

	// The shadowed 2A rule can never produce a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.format_code != pfrs_pkg::FMT_2A))
	else $error("format 2A produced");

	// A full input register that cannot move on must hold off the source.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !rsp.ready) |-> !req.ready)
	else $error("request taken while pipeline is blocked");

	// A word left in the input register reaches the result register once it drains.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> v_s2)
	else $error("request word lost between stages");

endmodule

// ===== rtl/core/pfrs_cfg_regs.sv =====
// Configuration register file written through a plain write port.
// Depends on pfrs_pkg for the register codes and the configuration struct.
module pfrs_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pfrs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfrs_pkg::CFG_DATA_W-1:0]    cfg_data,
	output pfrs_pkg::cfg_t                     cfg
);

	pfrs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfrs_pkg::REG_SR_RESOURCE: begin
					cfg_q.sr_resource <= cfg_data[pfrs_pkg::RES_IDX_W-1:0];
				end
				pfrs_pkg::REG_SPS_ENABLE: begin
					cfg_q.sps_enable <= cfg_data[0];
				end
				pfrs_pkg::REG_SPS_TABLE: begin
					cfg_q.sps_table <= cfg_data;
				end
				pfrs_pkg::REG_TPC_FIELD: begin
					cfg_q.tpc_field <= cfg_data[1:0];
				end
				pfrs_pkg::REG_FIRST_CCE: begin
					cfg_q.first_cce <= cfg_data[6:0];
				end
				pfrs_pkg::REG_ACK_OFFSET: begin
					cfg_q.ack_offset <= cfg_data[pfrs_pkg::RES_IDX_W-1:0];
				end
				pfrs_pkg::REG_CQI_RESOURCE: begin
					cfg_q.cqi_resource <= cfg_data[pfrs_pkg::RES_IDX_W-1:0];
				end
				pfrs_pkg::REG_EXTENDED_CP: begin
					cfg_q.extended_cp <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/pfrs_select.sv =====
// Format priority chain and resource index selection for one registered request.
// Depends on pfrs_pkg for the request, result and configuration types.
module pfrs_select (
	input  pfrs_pkg::req_t req,
	input  pfrs_pkg::cfg_t cfg,
	output pfrs_pkg::res_t res
);

	logic                          ack0;
	logic                          ack1;
	logic                          ack2;
	logic                          cqi_ok;
	logic                          ok;
	logic [2:0]                    fmt;
	logic [pfrs_pkg::CQI_BITS-1:0] payload;
	logic [1:0]                    dmrs;
	logic [11:0]                   res_idx;
	logic [1:0]                    ack_pair;

	assign ack0     = (req.ack_len == 2'd0);
	assign ack1     = (req.ack_len == 2'd1);
	assign ack2     = (req.ack_len == 2'd2);
	assign cqi_ok   = (req.cqi_len == 5'(pfrs_pkg::CQI_BITS));
	assign ack_pair = {req.ack_second, req.ack_first};

	// The chain is kept in its original order, so the 2A rule and the
	// extended-prefix 2B rule are shadowed by the ACK-length-one rule.
	always_comb begin
		ok      = 1'b1;
		fmt     = pfrs_pkg::FMT_1;
		payload = '0;
		dmrs    = '0;
		priority if (ack1) begin
			fmt     = pfrs_pkg::FMT_1A;
			payload = pfrs_pkg::CQI_BITS'(req.ack_first);
		end else if (ack2 && req.sched_request) begin
			fmt     = pfrs_pkg::FMT_1B;
			payload = pfrs_pkg::CQI_BITS'(ack_pair);
		end else if (ack2 && req.chan_select) begin
			fmt     = pfrs_pkg::FMT_1B;
			payload = pfrs_pkg::CQI_BITS'(ack_pair);
		end else if (req.sched_request) begin
			fmt     = pfrs_pkg::FMT_1;
		end else if (cqi_ok && ack0) begin
			fmt     = pfrs_pkg::FMT_2;
			payload = req.cqi_bits;
		end else if (cqi_ok && ack1) begin
			fmt     = pfrs_pkg::FMT_2A;
			payload = req.cqi_bits;
			dmrs    = {1'b0, req.ack_first};
		end else if (cqi_ok && ack2) begin
			fmt     = pfrs_pkg::FMT_2B;
			payload = req.cqi_bits;
			dmrs    = ack_pair;
		end else if (cqi_ok && ack1 && cfg.extended_cp) begin
			fmt     = pfrs_pkg::FMT_2B;
			payload = req.cqi_bits;
			dmrs    = ack_pair;
		end else begin
			ok      = 1'b0;
		end
	end

	always_comb begin
		priority if (fmt == pfrs_pkg::FMT_1) begin
			res_idx = 12'(cfg.sr_resource);
		end else if (fmt == pfrs_pkg::FMT_1A || fmt == pfrs_pkg::FMT_1B) begin
			if (cfg.sps_enable) begin
				res_idx = 12'(cfg.sps_table[cfg.tpc_field]);
			end else begin
				res_idx = 12'(cfg.first_cce) + 12'(cfg.ack_offset);
			end
		end else begin
			res_idx = 12'(cfg.cqi_resource);
		end
	end

	always_comb begin
		res.status         = ~ok;
		res.format_code    = ok ? fmt : 3'd0;
		res.resource_index = ok ? res_idx : 12'd0;
		res.payload_bits   = ok ? payload : '0;
		res.dmrs_bits      = ok ? dmrs : 2'd0;
	end

endmodule

// ===== tb/tb_pucch_format_and_resource_select.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pucch_format_and_resource_select: random and directed requests
// are checked against a predictor of the format chain and resource pick, across configurations.
// Depends on pfrs_pkg, the pfrs_req_if and pfrs_res_if interfaces and the block's RTL.
module tb_pucch_format_and_resource_select;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pfrs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pfrs_pkg::CFG_DATA_W-1:0] cfg_data;

	pfrs_req_if req_ch ();
	pfrs_res_if rsp_ch ();

	pucch_format_and_resource_select DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #1 clk = ~clk;

	pfrs_pkg::cfg_t cfg_shadow;
	pfrs_pkg::req_t pending_requests[$];
	pfrs_pkg::res_t expected_results[$];
	pfrs_pkg::res_t oldest_result;
	int             error_count;
	int             send_idle_pct;
	int             recv_idle_pct;
	bit             hold_requests;

	task automatic report_error(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_count++;
	endtask

	function automatic pfrs_pkg::res_t predict_result(pfrs_pkg::req_t r);
		pfrs_pkg::res_t o;
		logic           matched;
		logic           cqi_ok;
		logic [1:0]     acks;
		logic [11:0]    dyn_resource;
		o = '0;
		matched = 1'b1;
		cqi_ok = (r.cqi_len == 5'(pfrs_pkg::CQI_BITS));
		acks = {r.ack_second, r.ack_first};
		dyn_resource = 12'(cfg_shadow.first_cce) + 12'(cfg_shadow.ack_offset);
		if (r.ack_len == 2'd1) begin
			o.format_code = pfrs_pkg::FMT_1A;
			o.payload_bits = pfrs_pkg::CQI_BITS'(r.ack_first);
		end else if (r.ack_len == 2'd2 && (r.sched_request || r.chan_select)) begin
			o.format_code = pfrs_pkg::FMT_1B;
			o.payload_bits = pfrs_pkg::CQI_BITS'(acks);
		end else if (r.sched_request) begin
			o.format_code = pfrs_pkg::FMT_1;
		end else if (cqi_ok && r.ack_len == 2'd0) begin
			o.format_code = pfrs_pkg::FMT_2;
			o.payload_bits = r.cqi_bits;
		end else if (cqi_ok && r.ack_len == 2'd2) begin
			o.format_code = pfrs_pkg::FMT_2B;
			o.payload_bits = r.cqi_bits;
			o.dmrs_bits = acks;
		end else begin
			matched = 1'b0;
		end
		if (!matched) begin
			o = '0;
			o.status = 1'b1;
		end else if (o.format_code == pfrs_pkg::FMT_1) begin
			o.resource_index = 12'(cfg_shadow.sr_resource);
		end else if (o.format_code == pfrs_pkg::FMT_1A ||
			o.format_code == pfrs_pkg::FMT_1B) begin
			if (cfg_shadow.sps_enable)
				o.resource_index = 12'(cfg_shadow.sps_table[cfg_shadow.tpc_field]);
			else
				o.resource_index = dyn_resource;
		end else begin
			o.resource_index = 12'(cfg_shadow.cqi_resource);
		end
		return o;
	endfunction

	function automatic pfrs_pkg::req_t make_req(logic [1:0] len, logic a0, logic a1, logic sr,
		logic cs, logic [4:0] clen, logic [pfrs_pkg::CQI_BITS-1:0] cbits);
		pfrs_pkg::req_t r;
		r.ack_len = len;
		r.ack_first = a0;
		r.ack_second = a1;
		r.sched_request = sr;
		r.chan_select = cs;
		r.cqi_len = clen;
		r.cqi_bits = cbits;
		return r;
	endfunction

	function automatic pfrs_pkg::req_t random_req();
		pfrs_pkg::req_t r;
		logic [31:0]    bits;
		bits = $urandom;
		r.ack_len = 2'($urandom_range(3));
		r.ack_first = 1'($urandom_range(1));
		r.ack_second = 1'($urandom_range(1));
		r.sched_request = 1'($urandom_range(1));
		r.chan_select = 1'($urandom_range(1));
		r.cqi_len = 5'($urandom_range(1) ? pfrs_pkg::CQI_BITS : $urandom_range(31));
		r.cqi_bits = bits[pfrs_pkg::CQI_BITS-1:0];
		return r;
	endfunction

	task automatic write_reg(logic [pfrs_pkg::CFG_IDX_W-1:0] idx,
		logic [pfrs_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		unique case (idx)
			pfrs_pkg::REG_SR_RESOURCE:
				cfg_shadow.sr_resource = value[pfrs_pkg::RES_IDX_W-1:0];
			pfrs_pkg::REG_SPS_ENABLE:   cfg_shadow.sps_enable = value[0];
			pfrs_pkg::REG_SPS_TABLE:
				cfg_shadow.sps_table = value[4*pfrs_pkg::RES_IDX_W-1:0];
			pfrs_pkg::REG_TPC_FIELD:    cfg_shadow.tpc_field = value[1:0];
			pfrs_pkg::REG_FIRST_CCE:    cfg_shadow.first_cce = value[6:0];
			pfrs_pkg::REG_ACK_OFFSET:
				cfg_shadow.ack_offset = value[pfrs_pkg::RES_IDX_W-1:0];
			pfrs_pkg::REG_CQI_RESOURCE:
				cfg_shadow.cqi_resource = value[pfrs_pkg::RES_IDX_W-1:0];
			pfrs_pkg::REG_EXTENDED_CP:  cfg_shadow.extended_cp = value[0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_config(pfrs_pkg::cfg_t c);
		write_reg(pfrs_pkg::REG_SR_RESOURCE, pfrs_pkg::CFG_DATA_W'(c.sr_resource));
		write_reg(pfrs_pkg::REG_SPS_ENABLE, pfrs_pkg::CFG_DATA_W'(c.sps_enable));
		write_reg(pfrs_pkg::REG_SPS_TABLE, c.sps_table);
		write_reg(pfrs_pkg::REG_TPC_FIELD, pfrs_pkg::CFG_DATA_W'(c.tpc_field));
		write_reg(pfrs_pkg::REG_FIRST_CCE, pfrs_pkg::CFG_DATA_W'(c.first_cce));
		write_reg(pfrs_pkg::REG_ACK_OFFSET, pfrs_pkg::CFG_DATA_W'(c.ack_offset));
		write_reg(pfrs_pkg::REG_CQI_RESOURCE, pfrs_pkg::CFG_DATA_W'(c.cqi_resource));
		write_reg(pfrs_pkg::REG_EXTENDED_CP, pfrs_pkg::CFG_DATA_W'(c.extended_cp));
	endtask

	task automatic wait_for_drain();
		do @(negedge clk);
		while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// A new word is offered only once the current one has been taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_results.push_back(predict_result(req_ch.data));
			if (!req_ch.valid || req_ch.ready) begin
				if (hold_requests || pending_requests.size() == 0 ||
					$urandom_range(99) < send_idle_pct) begin
					req_ch.valid <= 1'b0;
				end else begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pending_requests.pop_front();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_error("result word with nothing expected");
				end else begin
					oldest_result = expected_results.pop_front();
					if (rsp_ch.data.status !== oldest_result.status)
						report_error($sformatf("status expected %0d got %0d",
							oldest_result.status, rsp_ch.data.status));
					if (rsp_ch.data.format_code !== oldest_result.format_code)
						report_error($sformatf("format_code expected %0d got %0d",
							oldest_result.format_code, rsp_ch.data.format_code));
					if (rsp_ch.data.resource_index !== oldest_result.resource_index)
						report_error($sformatf("resource_index expected %0d got %0d",
							oldest_result.resource_index, rsp_ch.data.resource_index));
					if (rsp_ch.data.payload_bits !== oldest_result.payload_bits)
						report_error($sformatf("payload_bits expected %h got %h",
							oldest_result.payload_bits, rsp_ch.data.payload_bits));
					if (rsp_ch.data.dmrs_bits !== oldest_result.dmrs_bits)
						report_error($sformatf("dmrs_bits expected %0d got %0d",
							oldest_result.dmrs_bits, rsp_ch.data.dmrs_bits));
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		#400000;
		$display("[pucch_format_and_resource_select] ERROR");
		$finish;
	end

	initial begin
		pfrs_pkg::cfg_t c;
		logic [63:0]    wide;
		int             n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cfg_shadow = '0;
		error_count = 0;
		send_idle_pct = 20;
		recv_idle_pct = 88;
		hold_requests = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// The largest dynamic resource: both the CCE and the offset at their maximum.
		wide = {$urandom, $urandom};
		c = '0;
		c.sr_resource = '1;
		c.sps_table = wide[4*pfrs_pkg::RES_IDX_W-1:0];
		c.first_cce = '1;
		c.ack_offset = '1;
		c.cqi_resource = '1;
		c.extended_cp = 1'b1;
		apply_config(c);

		// An SR together with one ACK bit still selects 1A, and the would-be 2A and
		// extended-CP 2B requests fall into 1A as well.
		pending_requests.push_back(make_req(2'd1, 1'b1, 1'b1, 1'b1, 1'b1, 5'd20, '1));
		pending_requests.push_back(make_req(2'd1, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, '0));
		pending_requests.push_back(make_req(2'd1, 1'b1, 1'b0, 1'b0, 1'b0, 5'd20, 20'h5A5A5));
		pending_requests.push_back(make_req(2'd2, 1'b1, 1'b1, 1'b1, 1'b0, 5'd31, '1));
		pending_requests.push_back(make_req(2'd2, 1'b0, 1'b1, 1'b0, 1'b1, 5'd0, '0));
		pending_requests.push_back(make_req(2'd2, 1'b1, 1'b0, 1'b1, 1'b1, 5'd20, 20'h12345));
		pending_requests.push_back(make_req(2'd2, 1'b1, 1'b0, 1'b0, 1'b0, 5'd20, '1));
		pending_requests.push_back(make_req(2'd2, 1'b0, 1'b1, 1'b0, 1'b0, 5'd20, '0));
		pending_requests.push_back(make_req(2'd2, 1'b1, 1'b1, 1'b0, 1'b0, 5'd19, '1));
		pending_requests.push_back(make_req(2'd0, 1'b1, 1'b1, 1'b1, 1'b0, 5'd20, '1));
		pending_requests.push_back(make_req(2'd3, 1'b0, 1'b0, 1'b1, 1'b1, 5'd0, '0));
		pending_requests.push_back(make_req(2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd20, '1));
		pending_requests.push_back(make_req(2'd0, 1'b1, 1'b1, 1'b0, 1'b0, 5'd20, '0));
		pending_requests.push_back(make_req(2'd3, 1'b1, 1'b1, 1'b0, 1'b0, 5'd20, '1));
		pending_requests.push_back(make_req(2'd3, 1'b0, 1'b0, 1'b0, 1'b1, 5'd21, 20'hA5A5A));
		pending_requests.push_back(make_req(2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd31, '1));
		pending_requests.push_back(make_req(2'd0, 1'b1, 1'b1, 1'b0, 1'b1, 5'd0, '0));
		pending_requests.push_back(make_req(2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd1, 20'h00001));
		wait_for_drain();

		for (int round = 0; round < 6; round++) begin
			wide = {$urandom, $urandom};
			c = '0;
			if (round == 1) begin
				c = '1;
			end else if (round > 1) begin
				c.sr_resource = pfrs_pkg::RES_IDX_W'($urandom_range(2047));
				c.sps_enable = 1'($urandom_range(1));
				c.sps_table = wide[4*pfrs_pkg::RES_IDX_W-1:0];
				c.tpc_field = 2'($urandom_range(3));
				c.first_cce = 7'($urandom_range(127));
				c.ack_offset = pfrs_pkg::RES_IDX_W'($urandom_range(2047));
				c.cqi_resource = pfrs_pkg::RES_IDX_W'($urandom_range(2047));
				c.extended_cp = 1'($urandom_range(1));
			end
			apply_config(c);
			send_idle_pct = (round < 2) ? 20 : (round < 4) ? 88 : 0;
			recv_idle_pct = (round < 2) ? 88 : (round < 4) ? 20 : 0;
			for (n = 0; n < 140; n++)
				pending_requests.push_back(random_req());
			if (round == 3) begin
				do @(negedge clk); while (pending_requests.size() > 70);
				hold_requests = 1'b1;
				do @(negedge clk); while (req_ch.valid || expected_results.size() != 0);
				hold_requests = 1'b0;
			end
			wait_for_drain();
		end

		if (error_count == 0)
			$display("[pucch_format_and_resource_select] OK");
		else
			$display("[pucch_format_and_resource_select] ERROR");
		$finish;
	end

endmodule
